// ===== rtl/length_prefixed_key_parser_top_macros.svh =====
// Assertion helpers for the parser RTL.
`ifndef LENGTH_PREFIXED_KEY_PARSER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_KEY_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define LPKP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lpkp: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define LPKP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lpkp: next-cycle check failed");

`endif

// ===== rtl/lpkp_pkg.sv =====
`timescale 1ns / 1ps
package lpkp_pkg;

    localparam int unsigned DEF_MAX_COMPONENTS = 8;
    localparam int unsigned DEF_LONG_MARKER    = 255;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned COMP_W  = 4;
    localparam int unsigned KIND_W  = 2;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_HEADER  = 2'd0;
    localparam t_kind KIND_START   = 2'd1;
    localparam t_kind KIND_PAYLOAD = 2'd2;
    localparam t_kind KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              end_of_key;
    } t_in_item;

    typedef struct packed {
        t_kind             byte_kind;
        logic [IDX_W-1:0]  component_index;
        logic [LEN_W-1:0]  component_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              key_done;
        logic              truncated;
    } t_result;

endpackage

// ===== rtl/lpkp_if.sv =====
`timescale 1ns / 1ps
// Byte request channel into the parser.
interface lpkp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       end_of_key;

    modport source (output valid, output key_byte, output end_of_key, input ready);
    modport sink   (input valid, input key_byte, input end_of_key, output ready);
endinterface

// Per-byte classification channel out of the parser.
interface lpkp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_kind;
    logic [2:0]  component_index;
    logic [15:0] component_length;
    logic [7:0]  payload_byte;
    logic        key_done;
    logic        truncated;

    modport source (output valid, output byte_kind, output component_index,
                    output component_length, output payload_byte, output key_done,
                    output truncated, input ready);
    modport sink   (input valid, input byte_kind, input component_index,
                    input component_length, input payload_byte, input key_done,
                    input truncated, output ready);
endinterface

// ===== rtl/lpkp_in_reg.sv =====
`timescale 1ns / 1ps
module lpkp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lpkp_in_if.sink           i_key,
    input  logic              i_take,
    output logic              o_valid,
    output lpkp_pkg::t_in_item o_item
);
    import lpkp_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_accept;

    // Open the slot when empty or when the held request moves on.
    assign i_key.ready = !r_valid || i_take;
    assign w_accept    = i_key.valid && i_key.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.key_byte   <= i_key.key_byte;
            r_item.end_of_key <= i_key.end_of_key;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== rtl/lpkp_core.sv =====
`timescale 1ns / 1ps
`include "length_prefixed_key_parser_top_macros.svh"
module lpkp_core #(
    parameter int unsigned MAX_COMPONENTS = lpkp_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned LONG_MARKER    = lpkp_pkg::DEF_LONG_MARKER
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  lpkp_pkg::t_in_item i_item,
    output lpkp_pkg::t_result  o_result
);
    import lpkp_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LEN_HI  = 2'd1;
    localparam logic [1:0] PH_LEN_LO  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [COMP_W-1:0] COMP_LIMIT = COMP_W'(MAX_COMPONENTS);
    localparam logic [BYTE_W-1:0] MARKER     = BYTE_W'(LONG_MARKER);

    logic [1:0]        r_phase,  n_phase;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic [COMP_W-1:0] r_comp,   n_comp;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;

    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_remain_dec;
    logic [COMP_W-1:0] w_idx;
    t_kind             w_kind;
    logic              w_start;

    always_comb begin
        n_phase      = r_phase;
        n_remain     = r_remain;
        n_comp       = r_comp;
        n_len_hi     = r_len_hi;
        w_kind       = KIND_IGNORED;
        w_idx        = '0;
        w_len        = '0;
        w_start      = 1'b0;
        w_remain_dec = r_remain - LEN_W'(1);

        unique case (r_phase)
            PH_HEADER: begin
                if (r_comp >= COMP_LIMIT) begin
                    w_kind = KIND_IGNORED;
                end else if (i_item.key_byte == MARKER) begin
                    w_kind  = KIND_HEADER;
                    w_idx   = r_comp;
                    n_phase = PH_LEN_HI;
                end else begin
                    w_kind  = KIND_START;
                    w_len   = LEN_W'(i_item.key_byte);
                    w_start = 1'b1;
                end
            end
            PH_LEN_HI: begin
                w_kind   = KIND_HEADER;
                w_idx    = r_comp;
                n_len_hi = i_item.key_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                w_kind  = KIND_START;
                w_len   = {r_len_hi, i_item.key_byte};
                w_start = 1'b1;
            end
            PH_PAYLOAD: begin
                w_kind   = KIND_PAYLOAD;
                w_idx    = r_comp - COMP_W'(1);
                n_remain = w_remain_dec;
                if (w_remain_dec == '0) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // Open a component: take its index, load the payload count.
        if (w_start) begin
            w_idx    = r_comp;
            n_comp   = r_comp + COMP_W'(1);
            n_remain = w_len;
            n_phase  = (w_len != '0) ? PH_PAYLOAD : PH_HEADER;
        end

        o_result.byte_kind        = w_kind;
        o_result.component_index  = w_idx[IDX_W-1:0];
        o_result.component_length = w_len;
        o_result.payload_byte     = (w_kind == KIND_PAYLOAD) ? i_item.key_byte : '0;
        o_result.key_done         = i_item.end_of_key;
        o_result.truncated        = i_item.end_of_key && (n_phase != PH_HEADER);

        // Drop all parse state at the end of a key.
        if (i_item.end_of_key) begin
            n_phase  = PH_HEADER;
            n_remain = '0;
            n_comp   = '0;
            n_len_hi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_remain <= '0;
            r_comp   <= '0;
            r_len_hi <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_comp   <= n_comp;
            r_len_hi <= n_len_hi;
        end
    end

    `LPKP_ASSERT_IMP(a_comp_bounded, i_clk, i_rst_n, 1'b1, r_comp <= COMP_LIMIT)
    `LPKP_ASSERT_IMP(a_payload_nonzero, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_remain != '0)
    `LPKP_ASSERT_NXT(a_end_clears, i_clk, i_rst_n, i_step && i_item.end_of_key,
                     r_phase == PH_HEADER && r_comp == '0)
endmodule

// ===== rtl/lpkp_out_reg.sv =====
`timescale 1ns / 1ps
module lpkp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lpkp_pkg::t_result i_result,
    output logic              o_can_load,
    lpkp_out_if.source        o_res
);
    import lpkp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Take a new result when empty or when the held one leaves this cycle.
    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.byte_kind        = r_result.byte_kind;
    assign o_res.component_index  = r_result.component_index;
    assign o_res.component_length = r_result.component_length;
    assign o_res.payload_byte     = r_result.payload_byte;
    assign o_res.key_done         = r_result.key_done;
    assign o_res.truncated        = r_result.truncated;
endmodule

// ===== rtl/length_prefixed_key_parser_top.sv =====
`timescale 1ns / 1ps
// Length-prefixed compound key parser.
// i_key carries one encoded key byte per request, with end_of_key set on the
// last byte of a key. o_res returns exactly one classification per byte:
// header byte, component start (index and decoded length), payload byte, or
// ignored once MAX_COMPONENTS components have started. A header byte equal to
// LONG_MARKER announces a two-byte length, high byte first.
// A byte accepted into the input register passes through the combinational
// core into the result register once that register has room.
// Throughput: one byte per cycle unless o_res stalls. Phase, remaining-count
// and component counter update as a byte moves on to the result register.
// The end of a key returns the parser to the header phase; a key ending with
// length or payload bytes still due is flagged truncated.
// Reset (i_rst_n low, synchronous) empties both registers and clears the parse
// state to the header phase with zero components.
// When the receiver stalls, the result register holds its request, an empty
// input register takes one more byte, then i_key.ready drops until o_res drains.
module length_prefixed_key_parser_top #(
    parameter int unsigned MAX_COMPONENTS = lpkp_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned LONG_MARKER    = lpkp_pkg::DEF_LONG_MARKER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpkp_in_if.sink     i_key,
    lpkp_out_if.source  o_res
);
    import lpkp_pkg::*;

    logic     w_in_valid;
    t_in_item w_in_item;
    t_result  w_result;
    logic     w_can_load;
    logic     w_step;

    // Advance the held byte whenever the result register has room.
    assign w_step = w_in_valid && w_can_load;

    lpkp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (i_key),
        .i_take  (w_can_load),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    lpkp_core #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .LONG_MARKER    (LONG_MARKER)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (w_in_item),
        .o_result (w_result)
    );

    lpkp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_res      (o_res)
    );
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the length-prefixed key parser: drive encoded key bytes on
// the request channel, predict one classification per accepted byte, and
// compare each returned request field by field in arrival order.
module tb_top;

    import lpkp_pkg::*;

    // Parser configuration under test: the package defaults.
    localparam int unsigned TB_MAX_COMPONENTS = DEF_MAX_COMPONENTS;
    localparam int unsigned TB_LONG_MARKER    = DEF_LONG_MARKER;

    localparam int RANDOM_BYTES  = 1000;
    // Both sides can idle before each byte, and a long final key can carry the run
    // to about 4000 bytes; the limit allows for both with a wide margin.
    localparam int CYCLE_LIMIT   = 500000;
    // Idle time after the final drain, so that a stray result can still show.
    localparam int SETTLE_CYCLES = 8;

    // Parse phases, mirrored from the block's behavior.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LEN_HI  = 2'd1,
        PH_LEN_LO  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    logic i_clk;
    logic i_rst_n;

    lpkp_in_if  key_if ();
    lpkp_out_if res_if ();

    length_prefixed_key_parser_top #(
        .MAX_COMPONENTS (TB_MAX_COMPONENTS),
        .LONG_MARKER    (TB_LONG_MARKER)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor state: what the parser should hold between bytes.
    t_phase      parse_phase_m;
    logic [15:0] bytes_left_m;
    logic [3:0]  comps_started_m;
    logic [7:0]  len_high_m;

    // Classifications predicted for accepted bytes, oldest first.
    t_result     pending_classes[$];
    // Bytes of the key being built for the next send.
    logic [7:0]  key_bytes[$];

    // Shared by both sides: when set, neither side idles.
    bit          no_gaps;

    int          error_count;
    int          bytes_sent;
    int          keys_sent;
    int          results_checked;
    int          truncated_seen;
    int          ignored_seen;
    int          starts_seen;

    // 4 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t ns: timeout, %0d classifications still pending", $time,
                 pending_classes.size());
        $display("tb_top failed");
        $finish;
    end

    // Return the predictor to the state the parser has after reset and after
    // every end of key.
    function automatic void clear_parse_state();
        parse_phase_m   = PH_HEADER;
        bytes_left_m    = '0;
        comps_started_m = '0;
        len_high_m      = '0;
    endfunction

    // Classify one byte and advance the predicted parse state.
    function automatic t_result classify_byte(logic [7:0] kb, logic last);
        t_result     r;
        logic [15:0] len;
        r           = '0;
        r.byte_kind = KIND_IGNORED;
        len         = '0;
        case (parse_phase_m)
            PH_HEADER: begin
                if (comps_started_m >= TB_MAX_COMPONENTS) begin
                    // Past the component limit: drop everything until key end.
                    r.byte_kind = KIND_IGNORED;
                end else if (kb == TB_LONG_MARKER) begin
                    r.byte_kind       = KIND_HEADER;
                    r.component_index = comps_started_m[2:0];
                    parse_phase_m     = PH_LEN_HI;
                end else begin
                    // Short header: the byte is the length itself.
                    len = {8'h00, kb};
                    r.byte_kind = KIND_START;
                end
            end
            PH_LEN_HI: begin
                r.byte_kind       = KIND_HEADER;
                r.component_index = comps_started_m[2:0];
                len_high_m        = kb;
                parse_phase_m     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len = {len_high_m, kb};
                r.byte_kind = KIND_START;
            end
            default: begin
                r.byte_kind       = KIND_PAYLOAD;
                r.payload_byte    = kb;
                r.component_index = 3'(comps_started_m - 4'd1);
                bytes_left_m      = bytes_left_m - 16'd1;
                if (bytes_left_m == 16'd0) begin
                    parse_phase_m = PH_HEADER;
                end
            end
        endcase

        // Open a component; a zero length closes it on the spot.
        if (r.byte_kind == KIND_START) begin
            r.component_index  = comps_started_m[2:0];
            r.component_length = len;
            comps_started_m    = comps_started_m + 4'd1;
            bytes_left_m       = len;
            parse_phase_m      = (len != 16'd0) ? PH_PAYLOAD : PH_HEADER;
        end

        r.key_done = last;
        if (last) begin
            // Anything still due at key end marks the key truncated.
            r.truncated = (parse_phase_m != PH_HEADER);
            clear_parse_state();
        end
        return r;
    endfunction

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    // Send one byte request: idle for a drawn number of cycles, then hold
    // valid until the parser takes it. Valid stays high on return so that a
    // back-to-back byte needs no second assignment in the same step.
    task automatic send_byte(logic [7:0] kb, logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            key_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_if.valid      <= 1'b1;
        key_if.key_byte   <= kb;
        key_if.end_of_key <= last;
        do @(posedge i_clk); while (key_if.ready !== 1'b1);
        pending_classes.push_back(classify_byte(kb, last));
        bytes_sent++;
    endtask

    // Send the bytes of key_bytes, flagging the last one as end of key.
    task automatic send_key();
        for (int i = 0; i < key_bytes.size(); i++) begin
            send_byte(key_bytes[i], i == key_bytes.size() - 1);
        end
        keys_sent++;
    endtask

    // Drop valid and hold off until every predicted classification is back.
    task automatic wait_for_results();
        key_if.valid <= 1'b0;
        while (pending_classes.size() != 0) @(posedge i_clk);
    endtask

    function automatic int draw_length();
        int r;
        r = $urandom_range(0, 15);
        if (r < 12) return $urandom_range(0, 6);
        if (r < 15) return $urandom_range(7, 40);
        return $urandom_range(41, 300);
    endfunction

    // Append one component: header (short or long form) and its payload.
    function automatic void append_component();
        int len;
        len = draw_length();
        // Lengths that collide with the marker or need two bytes go long form.
        if (len >= TB_LONG_MARKER || $urandom_range(0, 3) == 0) begin
            key_bytes.push_back(8'(TB_LONG_MARKER));
            key_bytes.push_back(8'(len >> 8));
            key_bytes.push_back(8'(len));
        end else begin
            key_bytes.push_back(8'(len));
        end
        repeat (len) key_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // A well-formed key; up to ten components so the limit is often crossed
    // and the trailing headers come back ignored.
    function automatic void build_wellformed_key();
        int n;
        key_bytes.delete();
        n = $urandom_range(1, 10);
        repeat (n) append_component();
    endfunction

    // Arbitrary bytes: exercises random header values and length byte patterns.
    function automatic void build_noise_key();
        int n;
        key_bytes.delete();
        n = $urandom_range(1, 12);
        repeat (n) key_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
                     exp_v, act_v);
            error_count++;
        end
    endtask

    // Result side: stall for a drawn number of cycles per request, then take
    // the next one and compare it with the oldest prediction.
    initial begin
        t_result want;
        int      stall;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            if (pending_classes.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got kind %0d",
                         $time, res_if.byte_kind);
                error_count++;
            end else begin
                want = pending_classes.pop_front();
                check_field("byte_kind", 16'(want.byte_kind), 16'(res_if.byte_kind));
                check_field("component_index", 16'(want.component_index),
                            16'(res_if.component_index));
                check_field("component_length", want.component_length,
                            res_if.component_length);
                check_field("payload_byte", 16'(want.payload_byte),
                            16'(res_if.payload_byte));
                check_field("key_done", 16'(want.key_done), 16'(res_if.key_done));
                check_field("truncated", 16'(want.truncated), 16'(res_if.truncated));
                results_checked++;
                if (want.truncated) truncated_seen++;
                if (want.byte_kind == KIND_IGNORED) ignored_seen++;
                if (want.byte_kind == KIND_START) starts_seen++;
            end
        end
    end

    // Zero-length component opens and closes on its only byte.
    task automatic test_zero_length();
        key_bytes = '{8'h00};
        send_key();
    endtask

    // Large short-form length ending on the start byte: truncated.
    task automatic test_short_truncated();
        key_bytes = '{8'hFE};
        send_key();
    endtask

    // Long-form header with a two-byte payload, all the way to a clean end.
    task automatic test_long_length();
        key_bytes = '{8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00};
        send_key();
    endtask

    // Keys cut off inside the long header: on the marker, on the high byte,
    // and on the low byte of the largest length.
    task automatic test_long_truncated();
        key_bytes = '{8'hFF};
        send_key();
        key_bytes = '{8'hFF, 8'h80};
        send_key();
        key_bytes = '{8'hFF, 8'hFF, 8'hFF};
        send_key();
    endtask

    // Hit the component limit: the last allowed component still carries
    // payload, then header-phase bytes are ignored until the key ends.
    task automatic test_component_limit();
        key_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h02, 8'hFF, 8'h00, 8'h05, 8'hFF};
        send_key();
    endtask

    // Mostly well-formed keys with random content, some cut short, some
    // noise; one pause partway through lets the pipeline drain completely.
    task automatic test_random_keys();
        int start_bytes;
        int pick;
        int cut;
        bit paused;
        start_bytes = bytes_sent;
        paused      = 1'b0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            pick    = $urandom_range(0, 19);
            if (pick < 14) begin
                build_wellformed_key();
            end else if (pick < 17) begin
                build_wellformed_key();
                if (key_bytes.size() > 1) begin
                    cut = $urandom_range(1, key_bytes.size() - 1);
                    while (key_bytes.size() > cut) void'(key_bytes.pop_back());
                end
            end else begin
                build_noise_key();
            end
            send_key();
            if (!paused && bytes_sent - start_bytes >= RANDOM_BYTES / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        error_count     = 0;
        bytes_sent      = 0;
        keys_sent       = 0;
        results_checked = 0;
        truncated_seen  = 0;
        ignored_seen    = 0;
        starts_seen     = 0;
        no_gaps         = 1'b0;
        clear_parse_state();

        // Hold reset with the request channel quiet.
        i_rst_n           <= 1'b0;
        key_if.valid      <= 1'b0;
        key_if.key_byte   <= '0;
        key_if.end_of_key <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_short_truncated();
        test_long_length();
        test_long_truncated();
        test_component_limit();
        test_random_keys();

        // Drain, then give the parser a few cycles to show any stray result.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d classifications over %0d keys (%0d bytes sent).",
                 results_checked, keys_sent, bytes_sent);
        $display("Seen: %0d component starts, %0d truncated keys, %0d ignored bytes.",
                 starts_seen, truncated_seen, ignored_seen);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
